>>> src/cma_pkg.sv
// shared constants and types for the centered moving average
package cma_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int MAX_HALF_WINDOW = 31;
	localparam int CFG_W = 6;
	localparam int HALF_W = 5;
	localparam int CNT_W = 6;
	localparam int LINE_DEPTH = 64;
	localparam int LINE_AW = 6;
	localparam int SEEN_LIMIT = 2 * MAX_HALF_WINDOW + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int DIV_DIGIT_BITS = 4;
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(1);

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_ADD,
		FS_EMIT,
		FS_SUB
	} front_state_t;

endpackage

>>> src/centered_moving_average.sv
// top level of the centered moving average with truncated frame edges
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------
// config   | cfg_valid / cfg_ready  | cfg_data (window size)
// input    | in_valid / in_ready    | sample, last_in
// output   | out_valid / out_ready  | average, last_out
//
// a sample passes front states idle and add, plus emit when it queues an
// average; a last sample adds emit, and sub when the count drops, per flushed
// average; the divider retires 4 quotient bits a cycle, holds its last step
// while the output stalls, and its one job at a time sets the sustained rate
// a 4 entry job queue lets the front run while the output side stalls
// reset clears all control state at once; the delay line needs no clearing
module centered_moving_average import cma_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          last_out
);

	localparam int SUM_BITS = SAMPLE_BITS + CNT_W;
	localparam int JOB_W = SUM_BITS + CNT_W + 1;

	logic                   fjob_valid;
	logic                   fjob_ready;
	logic [SUM_BITS-1:0]    fjob_sum;
	logic [CNT_W-1:0]       fjob_cnt;
	logic                   fjob_last;
	logic                   bjob_valid;
	logic                   bjob_ready;
	logic [JOB_W-1:0]       bjob_data;
	logic                   ram_we;
	logic [LINE_AW-1:0]     ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [LINE_AW-1:0]     ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	cma_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.last_in   (last_in),
		.job_valid (fjob_valid),
		.job_ready (fjob_ready),
		.job_sum   (fjob_sum),
		.job_cnt   (fjob_cnt),
		.job_last  (fjob_last),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	cma_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_line (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	cma_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fjob_valid),
		.in_ready  (fjob_ready),
		.in_data   ({fjob_sum, fjob_cnt, fjob_last}),
		.out_valid (bjob_valid),
		.out_ready (bjob_ready),
		.out_data  (bjob_data)
	);

	cma_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bjob_valid),
		.job_ready (bjob_ready),
		.job_sum   (bjob_data[JOB_W-1:CNT_W+1]),
		.job_cnt   (bjob_data[CNT_W:1]),
		.job_last  (bjob_data[0]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (average),
		.last_out  (last_out)
	);

endmodule

>>> src/cma_ram.sv
// generic single write port ram with registered read
module cma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/cma_front.sv
// front end: takes samples, keeps the running window sum and queues divide jobs
module cma_front import cma_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         last_in,
	output logic                         job_valid,
	input  logic                         job_ready,
	output logic [SAMPLE_BITS+CNT_W-1:0] job_sum,
	output logic [CNT_W-1:0]             job_cnt,
	output logic                         job_last,
	output logic                         ram_we,
	output logic [LINE_AW-1:0]           ram_waddr,
	output logic [SAMPLE_BITS-1:0]       ram_wdata,
	output logic                         ram_re,
	output logic [LINE_AW-1:0]           ram_raddr,
	input  logic [SAMPLE_BITS-1:0]       ram_rdata
);

	localparam int SUM_BITS = SAMPLE_BITS + CNT_W;

	front_state_t            state_q, state_d;
	logic [CFG_W-1:0]        window_size_q;
	logic [HALF_W-1:0]       h_q, h_d;
	logic [LINE_AW-1:0]      seen_q, seen_d;
	logic [LINE_AW-1:0]      wp_q, wp_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [SUM_BITS-1:0]     sum_q, sum_d;
	logic [HALF_W-1:0]       d_q, d_d;
	logic [SAMPLE_BITS-1:0]  sample_q, sample_d;
	logic                    last_q, last_d;
	logic                    drop_q, drop_d;

	logic [HALF_W-1:0]       half_cfg;
	logic [HALF_W-1:0]       h_new;
	logic [CNT_W-1:0]        win;
	logic [LINE_AW-1:0]      k;
	logic [HALF_W-1:0]       d_next;
	logic [LINE_AW-1:0]      span;
	logic [LINE_AW-1:0]      span_min;
	logic [CNT_W-1:0]        c_next;
	logic [SUM_BITS-1:0]     new_ext;
	logic [SUM_BITS-1:0]     old_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
		end else if (cfg_valid) begin
			window_size_q <= cfg_data;
		end
	end

	always_comb begin
		half_cfg = window_size_q[CFG_W-1:1];
		if (half_cfg > HALF_W'(MAX_HALF_WINDOW)) begin
			half_cfg = HALF_W'(MAX_HALF_WINDOW);
		end
		h_new = (seen_q == '0) ? half_cfg : h_q;
		win = {h_new, 1'b1};
		k = seen_q - LINE_AW'(1);
		d_next = d_q - HALF_W'(1);
		span = LINE_AW'(d_next) + LINE_AW'(h_q);
		span_min = (k < span) ? k : span;
		c_next = CNT_W'(span_min) + CNT_W'(1);
		new_ext = {{CNT_W{sample_q[SAMPLE_BITS-1]}}, sample_q};
		old_ext = {{CNT_W{ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
	end

	always_comb begin
		state_d = state_q;
		h_d = h_q;
		seen_d = seen_q;
		wp_d = wp_q;
		cnt_d = cnt_q;
		sum_d = sum_q;
		d_d = d_q;
		sample_d = sample_q;
		last_d = last_q;
		drop_d = drop_q;
		in_ready = 1'b0;
		job_valid = 1'b0;
		ram_we = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = sample;
		ram_re = 1'b0;
		ram_raddr = wp_q - LINE_AW'(win);
		unique case (state_q)
			FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_we = 1'b1;
					ram_re = 1'b1;
					h_d = h_new;
					drop_d = (cnt_q == win);
					sample_d = sample;
					last_d = last_in;
					wp_d = wp_q + LINE_AW'(1);
					if (seen_q < LINE_AW'(SEEN_LIMIT)) begin
						seen_d = seen_q + LINE_AW'(1);
					end
					state_d = FS_ADD;
				end
			end
			FS_ADD: begin
				sum_d = sum_q + new_ext - (drop_q ? old_ext : '0);
				cnt_d = drop_q ? cnt_q : cnt_q + CNT_W'(1);
				d_d = (k < LINE_AW'(h_q)) ? k[HALF_W-1:0] : h_q;
				if (last_q || k >= LINE_AW'(h_q)) begin
					state_d = FS_EMIT;
				end else begin
					state_d = FS_IDLE;
				end
			end
			FS_EMIT: begin
				job_valid = 1'b1;
				if (job_ready) begin
					if (!last_q || d_q == '0) begin
						if (last_q) begin
							seen_d = '0;
							sum_d = '0;
							cnt_d = '0;
						end
						state_d = FS_IDLE;
					end else begin
						d_d = d_next;
						if (c_next != cnt_q) begin
							ram_re = 1'b1;
							ram_raddr = wp_q - LINE_AW'(cnt_q);
							state_d = FS_SUB;
						end
					end
				end
			end
			FS_SUB: begin
				sum_d = sum_q - old_ext;
				cnt_d = cnt_q - CNT_W'(1);
				state_d = FS_EMIT;
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	assign job_sum = sum_q;
	assign job_cnt = cnt_q;
	assign job_last = last_q && (d_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			h_q <= '0;
			seen_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			d_q <= '0;
			last_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			state_q <= state_d;
			h_q <= h_d;
			seen_q <= seen_d;
			wp_q <= wp_d;
			cnt_q <= cnt_d;
			sum_q <= sum_d;
			d_q <= d_d;
			last_q <= last_d;
			drop_q <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		sample_q <= sample_d;
	end

endmodule

>>> src/cma_queue.sv
// small job queue between front and divider
module cma_queue import cma_pkg::*; #(
	parameter int WIDTH = 37,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;
	logic                push;
	logic                pop;

	assign in_ready = (fill_q != CNT_BITS'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data = entry_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_BITS'(1);
			end
		end
	end

endmodule

>>> src/cma_div.sv
// back end: iterative signed divide of window sum by count, truncating toward zero
module cma_div import cma_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  logic [SAMPLE_BITS+CNT_W-1:0]  job_sum,
	input  logic [CNT_W-1:0]              job_cnt,
	input  logic                          job_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          last_out
);

	localparam int SUM_BITS = SAMPLE_BITS + CNT_W;
	localparam int MAG_BITS = SUM_BITS - 1;
	localparam int NSTEP = (MAG_BITS + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS;
	localparam int PAD = NSTEP * DIV_DIGIT_BITS;
	localparam int STEP_W = $clog2(NSTEP);

	logic                   busy_q;
	logic [STEP_W-1:0]      step_q;
	logic [PAD-1:0]         quo_q, quo_n;
	logic [CNT_W-1:0]       rem_q, rem_n;
	logic [CNT_W-1:0]       div_q;
	logic                   neg_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic                   olast_q;
	logic [SUM_BITS-1:0]    mag;
	logic [PAD-1:0]         res;
	logic                   final_step;
	logic                   can_load;

	always_comb begin
		logic [CNT_W:0] r;
		logic           qbit;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int j = 0; j < DIV_DIGIT_BITS; j++) begin
			r = {rem_n, quo_n[PAD-1]};
			qbit = (r >= {1'b0, div_q});
			if (qbit) begin
				r = r - {1'b0, div_q};
			end
			rem_n = r[CNT_W-1:0];
			quo_n = {quo_n[PAD-2:0], qbit};
		end
	end

	assign mag = job_sum[SUM_BITS-1] ? (~job_sum + SUM_BITS'(1)) : job_sum;
	assign res = neg_q ? (~quo_n + PAD'(1)) : quo_n;
	assign final_step = busy_q && (step_q == STEP_W'(NSTEP - 1));
	assign can_load = !out_valid_q || out_ready;
	assign job_ready = !busy_q;
	assign out_valid = out_valid_q;
	assign average = avg_q;
	assign last_out = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q && job_valid) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q && !final_step) begin
				step_q <= step_q + STEP_W'(1);
			end else if (final_step && can_load) begin
				busy_q <= 1'b0;
			end
			if (final_step && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && job_valid) begin
			quo_q <= PAD'(mag[MAG_BITS-1:0]);
			rem_q <= '0;
			div_q <= job_cnt;
			neg_q <= job_sum[SUM_BITS-1];
			last_q <= job_last;
		end else if (busy_q && !final_step) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
		if (final_step && can_load) begin
			avg_q <= res[SAMPLE_BITS-1:0];
			olast_q <= last_q;
		end
	end

endmodule

>>> src/cma_checker.sv
// port level checks for the centered moving average, bound to the top level
module cma_checker import cma_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   last_in,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] average,
	input logic                   last_out
);

	// the front takes one sample and then works on it
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back to back cycles");

	// a frame end always queues at least one average before the next sample
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_in |=> !in_ready ##1 !in_ready)
		else $error("input taken too soon after frame end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(average) && $stable(last_out))
		else $error("output payload changed while stalled");

endmodule

bind centered_moving_average cma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cma_checker (.*);

>>> test/centered_moving_average_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for centered_moving_average with a running-window average predictor
module centered_moving_average_tb;
	import cma_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 120;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_TARGET = 280;
	localparam int CLOSING_ITEMS = 40;
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [CFG_W-1:0] WINDOW_MAX = '1;

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic                 is_last;
	} frame_sample_t;

	typedef struct packed {
		logic signed [SW-1:0] average;
		logic                 is_last;
	} window_mean_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = WINDOW_SIZE_RESET;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [SW-1:0] sample = '0;
	logic                 last_in = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [SW-1:0] average;
	logic                 last_out;

	frame_sample_t pending_samples[$];
	window_mean_t  expected_averages[$];

	// predictor state
	logic signed [SW-1:0] line_copy [LINE_DEPTH];
	logic [LINE_AW-1:0]   line_ptr = '0;
	int unsigned          frame_seen = 0;
	int unsigned          frame_half = 0;
	logic [CFG_W-1:0]     window_cfg = WINDOW_SIZE_RESET;

	bit idling_on = 1'b1;
	int sender_gap = 0;
	int receiver_stall = 0;
	int receiver_hold = 0;
	int hold_requests_made = 0;
	int hold_requests_seen = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int items_made = 0;
	int samples_taken = 0;
	int frames_done = 0;
	int averages_checked = 0;
	int windows_written = 0;

	centered_moving_average #(
		.SAMPLE_BITS(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average),
		.last_out(last_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [SW-1:0] mean_of_recent(int unsigned count);
		longint total;
		logic [LINE_AW-1:0] idx;
		total = 0;
		for (int unsigned n = 1; n <= count; n++) begin
			idx = line_ptr - LINE_AW'(n);
			total += line_copy[idx];
		end
		return SW'(total / longint'(count));
	endfunction

	function automatic void predict_averages(logic signed [SW-1:0] value, logic is_last);
		int unsigned k, d, lo, span, count;
		window_mean_t r;
		if (frame_seen == 0)
			frame_half = window_cfg / 2;
		line_copy[line_ptr] = value;
		line_ptr = line_ptr + 1'b1;
		if (frame_seen < SEEN_LIMIT)
			frame_seen++;
		k = frame_seen - 1;
		if (!is_last && k < frame_half)
			return;
		lo = is_last ? 0 : frame_half;
		d = (k < frame_half) ? k : frame_half;
		forever begin
			span = d + frame_half;
			count = ((k < span) ? k : span) + 1;
			r.average = mean_of_recent(count);
			r.is_last = is_last && d == 0;
			expected_averages = {expected_averages, r};
			if (d == lo)
				break;
			d--;
		end
		if (is_last)
			frame_seen = 0;
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SW'($signed($urandom_range(0, 31)) - 16);
			default: return SW'($urandom());
		endcase
	endfunction

	// sample driver
	always @(posedge clk) begin
		frame_sample_t item;
		logic next_valid;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				predict_averages(sample, last_in);
				samples_taken++;
				if (last_in)
					frames_done++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (sender_gap > 0) begin
					sender_gap--;
				end else if (idling_on && $urandom_range(0, 7) == 0) begin
					sender_gap = $urandom_range(1, 19) - 1;
				end else if (pending_samples.size() != 0) begin
					item = pending_samples.pop_front();
					sample <= item.value;
					last_in <= item.is_last;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// average monitor and receiver stalls
	always @(posedge clk) begin
		window_mean_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_averages.size() == 0) begin
					$error("average: expected none, actual %0d", average);
					error_count++;
				end else begin
					want = expected_averages.pop_front();
					averages_checked++;
					if (average !== want.average) begin
						$error("average: expected %0d, actual %0d", want.average, average);
						error_count++;
					end
					if (last_out !== want.is_last) begin
						$error("last_out: expected %0b, actual %0b", want.is_last, last_out);
						error_count++;
					end
				end
			end
			if (hold_requests_seen != hold_requests_made) begin
				hold_requests_seen = hold_requests_made;
				receiver_hold = LONG_HOLD;
			end
			if (receiver_hold > 0) begin
				receiver_hold--;
				out_ready <= 1'b0;
			end else if (receiver_stall > 0) begin
				receiver_stall--;
				out_ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				receiver_stall = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("centered_moving_average_tb: errors");
			$finish;
		end
	end

	task automatic queue_sample(logic signed [SW-1:0] value, logic is_last);
		frame_sample_t item;
		item.value = value;
		item.is_last = is_last;
		pending_samples = {pending_samples, item};
		items_made++;
	endtask

	task automatic queue_frame(int unsigned len, bit closed);
		for (int unsigned i = 0; i < len; i++)
			queue_sample(rand_sample(), closed && i == len - 1);
	endtask

	// every sample taken, every average back, then let the front settle
	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_averages.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		window_cfg = value;
		windows_written++;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(logic [CFG_W-1:0] window, int unsigned budget, bit may_leave_open);
		int unsigned half, len, start;
		bit closed;
		wait_idle();
		write_window(window);
		half = window / 2;
		start = items_made;
		while (items_made - start < budget) begin
			if ($urandom_range(0, 11) == 0)
				len = $urandom_range(64, 90);
			else
				len = $urandom_range(1, 2 * half + 6);
			closed = !(may_leave_open && items_made + len - start >= budget
				&& $urandom_range(0, 2) == 0);
			queue_frame(len, closed);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] window;
		for (int i = 0; i < LINE_DEPTH; i++)
			line_copy[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pass-through at the reset window size
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_MIN, 1'b1);
		wait_idle();
		write_window('0);
		queue_sample(SW'(-1), 1'b1);
		wait_idle();
		// widest window on a short frame
		write_window(WINDOW_MAX);
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_MIN, 1'b0);
		queue_sample(SAMPLE_MIN, 1'b0);
		queue_sample('0, 1'b1);
		wait_idle();
		write_window(CFG_W'(7));
		queue_sample(SAMPLE_MIN, 1'b1);
		wait_idle();
		// window change inside a frame
		write_window(CFG_W'(4));
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_MIN, 1'b0);
		queue_sample(SW'(1), 1'b0);
		wait_idle();
		write_window(CFG_W'(2));
		queue_sample(SW'(-1), 1'b0);
		queue_sample(SAMPLE_MIN, 1'b0);
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample('0, 1'b1);
		wait_idle();
		write_window(CFG_W'(3));
		queue_sample(SAMPLE_MIN, 1'b0);
		queue_sample(SAMPLE_MAX, 1'b0);
		queue_sample(SAMPLE_MIN, 1'b0);
		queue_sample(SAMPLE_MAX, 1'b1);

		// long receiver hold while a long frame streams in
		wait_idle();
		write_window(WINDOW_MAX);
		queue_frame(70, 1'b1);
		hold_requests_made = hold_requests_made + 1;

		while (items_made < RANDOM_TARGET) begin
			case ($urandom_range(0, 5))
				0: window = '0;
				1: window = WINDOW_MAX;
				2: window = WINDOW_MAX - 1'b1;
				3: window = CFG_W'($urandom_range(1, 4));
				default: window = CFG_W'($urandom_range(0, 63));
			endcase
			random_phase(window, $urandom_range(15, 50), 1'b1);
		end

		wait_idle();
		idling_on = 1'b0;
		random_phase(CFG_W'($urandom_range(0, 63)), CLOSING_ITEMS, 1'b0);
		wait_idle();

		$display("ran %0d samples in %0d frames through %0d window settings,",
			samples_taken, frames_done, windows_written);
		$display("checked %0d averages, %0d mismatches", averages_checked, error_count);
		if (error_count == 0)
			$display("centered_moving_average_tb: clean");
		else
			$display("centered_moving_average_tb: errors");
		$finish;
	end

endmodule
